>>> src/mlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Codes and the command/status bundles shared by controller and datapath.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // request action codes
  localparam logic ACT_SCHED = 1'b1;

  // schedule causes (a fourth code acts as a yield)
  localparam logic [1:0] RSN_SLICE = 2'd0;
  localparam logic [1:0] RSN_BLOCK = 2'd2;

  // configuration register indexes
  localparam logic CFG_USE_MLFQ = 1'b0;
  localparam logic CFG_BOOST    = 1'b1;

  typedef struct packed {
    logic capture;
    logic ready_push;
    logic sched_start;
    logic boost_load;
    logic boost_rd;
    logic boost_wr;
    logic boost_next;
    logic demote;
    logic disp_rd;
    logic disp_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_sched;
    logic boost_hit;
    logic rem_zero;
    logic bq_zero;
    logic found;
    logic out_busy;
  } status_t;

endpackage

>>> src/mlfq_thread_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ thread scheduler
// Four-level feedback-queue scheduler with a running-thread register.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns one result per request. A ready
// request steps through capture, queue push and result; a schedule request
// through capture, slice count, boost check, demote, dispatch read, requeue
// and result, with no requeue when there is no thread to dispatch. A boost
// adds a check, a read and a write per moved queue entry and a check per
// lower level, as each entry is read out of the queue memory into a register
// and then written to the level above. The result waits in an output
// register, so the next request is taken as soon as the controller is back in
// idle; a request whose result is ready holds while the previous is stalled.
// Configuration writes are taken at any time (cfg_ready is tied high) and
// must come only while no request is in flight.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler #(
  parameter int LEVELS      = 4,
  parameter int MAX_THREADS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [3:0]  thread_id,
  input  logic        new_thread,
  input  logic [1:0]  reason,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  running_thread,
  output logic        running_valid,
  output logic        switched,
  output logic [2:0]  running_level,
  output logic        queue_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mlfq_pkg::*;

  cmd_t    cmd;
  status_t st;

  // registers accept writes every cycle
  assign cfg_ready = 1'b1;

  // sequence each request: push, slice/boost, demote, dispatch, result
  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // hold queues, levels, running thread and the result register
  mlfq_dp #(
    .LEVELS      (LEVELS),
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .thread_id      (thread_id),
    .new_thread     (new_thread),
    .reason         (reason),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .running_thread (running_thread),
    .running_valid  (running_valid),
    .switched       (switched),
    .running_level  (running_level),
    .queue_full     (queue_full)
  );

endmodule

>>> src/mlfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mlfq_pkg::status_t st,
  output mlfq_pkg::cmd_t    cmd
);
  import mlfq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_READY  = 11'b00000000010,
    S_SCHED  = 11'b00000000100,
    S_BLOAD  = 11'b00000001000,
    S_BCHK   = 11'b00000010000,
    S_BRD    = 11'b00000100000,
    S_BWR    = 11'b00001000000,
    S_DEMOTE = 11'b00010000000,
    S_DRD    = 11'b00100000000,
    S_DWR    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = st.in_sched ? S_SCHED : S_READY;
        end
      end
      S_READY: begin
        cmd.ready_push = 1'b1;
        state_next     = S_DONE;
      end
      S_SCHED: begin
        cmd.sched_start = 1'b1;
        state_next      = S_BLOAD;
      end
      S_BLOAD: begin
        // skip the boost walk unless the slice counter hit the period
        if (st.boost_hit) begin
          cmd.boost_load = 1'b1;
          state_next     = S_BCHK;
        end else begin
          state_next = S_DEMOTE;
        end
      end
      S_BCHK: begin
        if (!st.rem_zero) begin
          state_next = S_BRD;
        end else if (st.bq_zero) begin
          state_next = S_DEMOTE;
        end else begin
          cmd.boost_next = 1'b1;
        end
      end
      S_BRD: begin
        cmd.boost_rd = 1'b1;
        state_next   = S_BWR;
      end
      S_BWR: begin
        cmd.boost_wr = 1'b1;
        state_next   = S_BCHK;
      end
      S_DEMOTE: begin
        cmd.demote = 1'b1;
        state_next = S_DRD;
      end
      S_DRD: begin
        cmd.disp_rd = 1'b1;
        state_next  = st.found ? S_DWR : S_DONE;
      end
      S_DWR: begin
        cmd.disp_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/mlfq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler datapath
// Queue memory, head/count pointers, thread levels and the result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
  parameter int LEVELS      = 4,
  parameter int MAX_THREADS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mlfq_pkg::cmd_t    cmd,
  output mlfq_pkg::status_t st,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              action,
  input  logic [3:0]        thread_id,
  input  logic              new_thread,
  input  logic [1:0]        reason,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        running_thread,
  output logic              running_valid,
  output logic              switched,
  output logic [2:0]        running_level,
  output logic              queue_full
);
  import mlfq_pkg::*;

  localparam int ID_W   = $clog2(MAX_THREADS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = ID_W + 1;
  localparam int DEPTH  = LEVELS * MAX_THREADS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [LVL_W-1:0] TOP   = LVL_W'(LEVELS - 1);
  localparam logic [CNT_W-1:0] CAP   = CNT_W'(MAX_THREADS);

  logic              use_mlfq;
  logic [15:0]       boost_period;
  logic [15:0]       slice_count;

  logic [ID_W-1:0]   fifo_mem [DEPTH];
  logic [ID_W-1:0]   fifo_head [LEVELS];
  logic [CNT_W-1:0]  fifo_count [LEVELS];
  logic [LVL_W-1:0]  thread_level [MAX_THREADS];

  logic [ID_W-1:0]   tid;
  logic              new_r;
  logic [1:0]        reason_r;
  logic [ID_W-1:0]   run_id;
  logic              run_present;
  logic              keep;
  logic              boost_hit;
  logic              full;
  logic              sw;
  logic [LVL_W-1:0]  bq;
  logic [CNT_W-1:0]  rem;
  logic [ID_W-1:0]   rdata;

  logic [4:0]        tid_red;
  logic [ID_W-1:0]   tid_in;
  logic [LVL_W-1:0]  lvl_rd;
  logic [LVL_W-1:0]  bq_m1;
  logic              found;
  logic [LVL_W-1:0]  disp_q;
  logic              push_en, push_ok, pop_en;
  logic [LVL_W-1:0]  push_q, pop_q;
  logic [ID_W-1:0]   push_id, push_pos, pop_head;
  logic [CNT_W-1:0]  push_sum;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ID_W-1:0]   head_inc;

  // thread id modulo the thread count
  always_comb begin
    tid_red = {1'b0, thread_id};
    if (MAX_THREADS < 16) begin
      for (int i = 0; i < 8; i++) begin
        if (tid_red >= 5'(MAX_THREADS)) tid_red = tid_red - 5'(MAX_THREADS);
      end
    end
    tid_in = ID_W'(tid_red);
  end

  assign lvl_rd = thread_level[cmd.ready_push ? tid : run_id];
  assign bq_m1  = bq - 1'b1;

  // highest non-empty queue (only the top queue when MLFQ is off)
  always_comb begin
    found  = 1'b0;
    disp_q = TOP;
    if (use_mlfq) begin
      for (int q = 0; q < LEVELS; q++) begin
        if (fifo_count[q] != '0) begin
          found  = 1'b1;
          disp_q = LVL_W'(q);
        end
      end
    end else begin
      found = (fifo_count[TOP] != '0);
    end
  end

  always_comb begin
    push_en = 1'b0;
    push_q  = new_r ? TOP : lvl_rd;
    push_id = tid;
    if (cmd.ready_push) begin
      push_en = 1'b1;
    end else if (cmd.boost_wr) begin
      push_en = 1'b1;
      push_q  = bq + 1'b1;
      push_id = rdata;
    end else if (cmd.disp_wr) begin
      push_en = keep;
      push_q  = use_mlfq ? lvl_rd : TOP;
      push_id = run_id;
    end
  end

  assign pop_en   = cmd.boost_rd | (cmd.disp_rd & found);
  assign pop_q    = cmd.boost_rd ? bq : disp_q;
  assign push_ok  = (fifo_count[push_q] != CAP);
  assign pop_head = fifo_head[pop_q];

  always_comb begin
    push_sum = {1'b0, fifo_head[push_q]} + fifo_count[push_q];
    if (push_sum >= CAP) push_sum = push_sum - CAP;
    push_pos = ID_W'(push_sum);
    head_inc = (pop_head == ID_W'(MAX_THREADS - 1)) ? '0 : pop_head + 1'b1;
  end

  assign waddr = ADDR_W'(int'(push_q) * MAX_THREADS + int'(push_pos));
  assign raddr = ADDR_W'(int'(pop_q) * MAX_THREADS + int'(pop_head));

  always_ff @(posedge clk) begin
    if (push_en && push_ok) fifo_mem[waddr] <= push_id;
    if (pop_en) rdata <= fifo_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < LEVELS; q++) begin
        fifo_head[q]  <= '0;
        fifo_count[q] <= '0;
      end
    end else begin
      for (int q = 0; q < LEVELS; q++) begin
        if (pop_en && pop_q == LVL_W'(q)) begin
          fifo_head[q]  <= head_inc;
          fifo_count[q] <= fifo_count[q] - 1'b1;
        end
        if (push_en && push_ok && push_q == LVL_W'(q)) begin
          fifo_count[q] <= fifo_count[q] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_THREADS; t++) thread_level[t] <= TOP;
    end else if (cmd.ready_push && new_r) begin
      thread_level[tid] <= TOP;
    end else if (cmd.boost_wr) begin
      thread_level[rdata] <= bq + 1'b1;
    end else if (cmd.demote && use_mlfq && keep && reason_r == RSN_SLICE &&
                 lvl_rd != '0) begin
      thread_level[run_id] <= lvl_rd - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_mlfq     <= 1'b1;
      boost_period <= 16'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USE_MLFQ: use_mlfq     <= cfg_data[0];
        CFG_BOOST:    boost_period <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_present <= 1'b0;
      run_id      <= '0;
      slice_count <= '0;
      boost_hit   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.sched_start) begin
        boost_hit <= 1'b0;
        if (!(run_present && reason_r != RSN_BLOCK)) run_present <= 1'b0;
        if (use_mlfq) begin
          if (slice_count + 16'd1 == boost_period) begin
            boost_hit   <= 1'b1;
            slice_count <= '0;
          end else begin
            slice_count <= slice_count + 16'd1;
          end
        end
      end
      if (cmd.disp_wr) begin
        run_id      <= rdata;
        run_present <= 1'b1;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.load_out) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tid      <= tid_in;
      new_r    <= new_thread;
      reason_r <= reason;
      full     <= 1'b0;
      sw       <= 1'b0;
    end
    if (cmd.sched_start) keep <= run_present && reason_r != RSN_BLOCK;
    if (push_en && !push_ok) full <= 1'b1;
    if (cmd.disp_wr) sw <= 1'b1;
    if (cmd.boost_load) begin
      bq  <= LVL_W'(LEVELS - 2);
      rem <= fifo_count[LEVELS-2];
    end
    if (cmd.boost_rd) rem <= rem - 1'b1;
    if (cmd.boost_next) begin
      bq  <= bq_m1;
      rem <= fifo_count[bq_m1];
    end
    if (cmd.load_out) begin
      running_thread <= run_present ? 4'(run_id) : 4'd0;
      running_valid  <= run_present;
      running_level  <= run_present ? 3'(lvl_rd) + 3'd1 : 3'd0;
      switched       <= sw;
      queue_full     <= full;
    end
  end

  assign st.in_sched  = (action == ACT_SCHED);
  assign st.boost_hit = boost_hit;
  assign st.rem_zero  = (rem == '0);
  assign st.bq_zero   = (bq == '0);
  assign st.found     = found;
  assign st.out_busy  = out_valid && out_stall;

endmodule

>>> tb/mlfq_thread_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ thread scheduler testbench
// Drives ready and schedule requests through the scheduler with random
// gaps and output stalls. A local scheduler model predicts every result,
// and each result is checked field by field. Runs several mode and boost
// period settings.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler_test;
  import mlfq_pkg::*;

  // codes the package leaves out
  localparam logic       ACT_READY = 1'b0;
  localparam logic [1:0] RSN_YIELD = 2'd1;
  localparam logic [1:0] RSN_ODD   = 2'd3;  // fourth cause, acts as a yield

  localparam int NLVL  = 4;
  localparam int NTHR  = 16;
  localparam int TOP   = NLVL - 1;

  typedef struct packed {
    logic       act;
    logic [3:0] tid;
    logic       fresh;
    logic [1:0] rsn;
  } sched_req_t;

  typedef struct packed {
    logic [3:0] thread;
    logic       valid;
    logic       sw;
    logic [2:0] level;
    logic       full;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [3:0]  thread_id = '0;
  logic        new_thread = 1'b0;
  logic [1:0]  reason = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  running_thread;
  logic        running_valid;
  logic        switched;
  logic [2:0]  running_level;
  logic        queue_full;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  mlfq_thread_scheduler dut (.*);

  always #4 clk = ~clk;

  // scheduler model state
  logic [3:0]  q_mem [NLVL][NTHR];
  int          q_head [NLVL];
  int          q_cnt [NLVL];
  logic [1:0]  thr_lvl [NTHR];
  logic [3:0]  cur_id;
  logic        cur_on;
  logic [15:0] slices;
  logic        mode_mlfq;
  logic [15:0] boost_every;

  sched_req_t  pending_reqs [$];
  sched_res_t  expected_res [$];
  int          errors = 0;
  int          n_results = 0;
  int          n_switches = 0;
  int          n_drops = 0;
  int          n_boosts = 0;
  logic        calm = 1'b0;   // stretch with no idling on either side

  function automatic logic enq(int q, logic [3:0] id);
    if (q_cnt[q] >= NTHR) return 1'b0;
    q_mem[q][(q_head[q] + q_cnt[q]) % NTHR] = id;
    q_cnt[q]++;
    return 1'b1;
  endfunction

  function automatic logic [3:0] deq(int q);
    logic [3:0] id;
    id = q_mem[q][q_head[q]];
    q_head[q] = (q_head[q] + 1) % NTHR;
    q_cnt[q]--;
    return id;
  endfunction

  // advance the model by one request and queue the result it produces
  task automatic predict_dispatch(input sched_req_t r);
    logic full, sw, keep;
    logic [3:0] id;
    int q, n;
    sched_res_t res;
    full = 1'b0;
    sw = 1'b0;
    if (r.act == ACT_READY) begin
      if (r.fresh) thr_lvl[r.tid] = 2'(TOP);
      if (!enq(thr_lvl[r.tid], r.tid)) full = 1'b1;
    end else begin
      keep = cur_on && r.rsn != RSN_BLOCK;
      if (!keep) cur_on = 1'b0;
      if (mode_mlfq) begin
        slices = slices + 16'd1;
        if (slices == boost_every) begin
          n_boosts++;
          // walk lower queues upward, top-most first
          for (q = NLVL - 2; q >= 0; q--) begin
            n = q_cnt[q];
            while (n > 0) begin
              n--;
              id = deq(q);
              thr_lvl[id] = 2'(q + 1);
              if (!enq(q + 1, id)) full = 1'b1;
            end
          end
          slices = '0;
        end
        if (keep && r.rsn == RSN_SLICE && thr_lvl[cur_id] != 0) thr_lvl[cur_id]--;
        for (q = TOP; q >= 0; q--) begin
          if (q_cnt[q] != 0) begin
            id = deq(q);
            if (keep && !enq(thr_lvl[cur_id], cur_id)) full = 1'b1;
            cur_id = id;
            cur_on = 1'b1;
            sw = 1'b1;
            break;
          end
        end
      end else if (q_cnt[TOP] != 0) begin
        id = deq(TOP);
        if (keep && !enq(TOP, cur_id)) full = 1'b1;
        cur_id = id;
        cur_on = 1'b1;
        sw = 1'b1;
      end
    end
    res.thread = cur_on ? cur_id : 4'd0;
    res.valid  = cur_on;
    res.level  = cur_on ? 3'(thr_lvl[cur_id]) + 3'd1 : 3'd0;
    res.sw     = sw;
    res.full   = full;
    expected_res.push_back(res);
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver: predict on acceptance, then load the next request
  int req_gap = 0;
  always @(posedge clk) begin
    sched_req_t nxt;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_dispatch('{action, thread_id, new_thread, reason});
        if ($urandom_range(0, 149) == 0) calm <= ~calm;
      end
      if (!in_valid || !in_stall) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          action     <= nxt.act;
          thread_id  <= nxt.tid;
          new_thread <= nxt.fresh;
          reason     <= nxt.rsn;
          in_valid   <= 1'b1;
          req_gap    <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check against the oldest prediction, then pick the stall
  int hold_cnt = 0;
  always @(posedge clk) begin
    sched_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_res.size() == 0) begin
          $error("result with no request pending: thread %0d", running_thread);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (switched) n_switches++;
          if (queue_full) n_drops++;
          if (running_thread !== want.thread) begin
            $error("running_thread: expected %0d, got %0d", want.thread, running_thread);
            errors++;
          end
          if (running_valid !== want.valid) begin
            $error("running_valid: expected %0d, got %0d", want.valid, running_valid);
            errors++;
          end
          if (switched !== want.sw) begin
            $error("switched: expected %0d, got %0d", want.sw, switched);
            errors++;
          end
          if (running_level !== want.level) begin
            $error("running_level: expected %0d, got %0d", want.level, running_level);
            errors++;
          end
          if (queue_full !== want.full) begin
            $error("queue_full: expected %0d, got %0d", want.full, queue_full);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        hold_cnt <= gap_len();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_USE_MLFQ) mode_mlfq = val[0];
    else boost_every = val;
  endtask

  task automatic add_req(input logic a, input logic [3:0] t, input logic f,
                         input logic [1:0] r);
    pending_reqs.push_back('{a, t, f, r});
  endtask

  // random traffic: bursts of ready requests mixed with schedule-heavy runs
  task automatic add_random(input int count);
    int i, k, len, t;
    i = 0;
    while (i < count) begin
      k = $urandom_range(0, 9);
      len = $urandom_range(4, 24);
      t = $urandom_range(0, NTHR - 1);
      for (int j = 0; j < len; j++) begin
        if (k < 2) begin
          // flood one thread to overflow a queue
          add_req(ACT_READY, 4'(t), 1'($urandom_range(0, 1)), 2'($urandom));
        end else if (k < 5) begin
          add_req(ACT_READY, 4'($urandom), $urandom_range(0, 3) == 0, 2'($urandom));
        end else begin
          if ($urandom_range(0, 99) < 60)
            add_req(ACT_SCHED, 4'($urandom), 1'($urandom), 2'($urandom_range(0, 3)));
          else
            add_req(ACT_READY, 4'($urandom), 1'($urandom), 2'($urandom));
        end
      end
      i += len;
    end
  endtask

  // hold until the block has drained every request of the phase
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    for (int q = 0; q < NLVL; q++) begin
      q_head[q] = 0;
      q_cnt[q] = 0;
    end
    for (int t = 0; t < NTHR; t++) thr_lvl[t] = 2'(TOP);
    cur_id = '0;
    cur_on = 1'b0;
    slices = '0;
    mode_mlfq = 1'b1;
    boost_every = 16'd8;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: schedule on empty, extremes of thread ids, every cause
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_YIELD);
    add_req(ACT_READY, 4'd0, 1'b1, 2'd0);
    add_req(ACT_READY, 4'd15, 1'b1, 2'd3);
    add_req(ACT_READY, 4'd9, 1'b0, 2'd0);
    add_req(ACT_SCHED, 4'd15, 1'b1, RSN_SLICE);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_SLICE);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_YIELD);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_ODD);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_BLOCK);
    add_req(ACT_READY, 4'd15, 1'b0, 2'd0);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_SLICE);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_BLOCK);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_BLOCK);
    add_req(ACT_SCHED, 4'd0, 1'b0, RSN_SLICE);
    add_random(200);
    drain();

    // boost on every schedule request
    cfg_write(CFG_USE_MLFQ, 16'd1);
    cfg_write(CFG_BOOST, 16'd1);
    add_random(250);
    drain();

    // round robin on the top queue
    cfg_write(CFG_USE_MLFQ, 16'd0);
    add_random(250);
    drain();

    // boosts effectively never happen: threads sink to the lowest level
    cfg_write(CFG_USE_MLFQ, 16'd1);
    cfg_write(CFG_BOOST, 16'hFFFF);
    add_random(300);
    drain();

    cfg_write(CFG_BOOST, 16'd3);
    add_random(300);
    drain();

    $display("%0d results checked, %0d dispatches, %0d drops on full queues, %0d boosts",
             n_results, n_switches, n_drops, n_boosts);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d requests outstanding", expected_res.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
src/mlfq_pkg.sv
src/mlfq_ctrl.sv
src/mlfq_dp.sv
src/mlfq_thread_scheduler.sv
tb/mlfq_thread_scheduler_test.sv
